// ----- hw/rtl/bda_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII unit.
package bda_pkg;

   localparam int DIGIT_BITS = 4;
   localparam int CHAR_BITS = 6;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

   typedef struct packed {
      logic valid;
      logic is_zero;
   } bda_hand_type;

endpackage

// ----- hw/rtl/binary_to_decimal_ascii_unit.sv -----
// Top level of the binary to decimal ASCII unit.
// Each input word is an unsigned value whose low VALUE_BITS bits are written out as
// ASCII decimal digits, most significant first, without leading zeros, one digit per
// result word, with rsp_last_digit set on the final digit; zero gives a single '0'.
// Inputs wait in a two-entry queue while the back end works. Each value runs through
// the shift-add-3 iteration, one input bit per step (skipped for zero); then leading
// zeros are skipped one digit position at a time and the digits are emitted, one per
// result word, as the result slot is free or popped.
module binary_to_decimal_ascii_unit
   import bda_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [31:0]          req_value,
   output logic                 req_full,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [CHAR_BITS-1:0] rsp_digit_char,
   output logic                 rsp_last_digit
);

   bda_hand_type          hand;
   logic [VALUE_BITS-1:0] hand_value;
   logic                  take;

   bda_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_value (req_value),
      .req_full  (req_full),
      .hand      (hand),
      .hand_value(hand_value),
      .take      (take)
   );

   bda_back #(
      .VALUE_BITS(VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .hand          (hand),
      .hand_value    (hand_value),
      .take          (take),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_digit_char(rsp_digit_char),
      .rsp_last_digit(rsp_last_digit)
   );

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_digit_char >= ASCII_ZERO) && (rsp_digit_char <= ASCII_ZERO + 6'd9))
      else $error("result word holds a non-digit character");

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      take |-> hand.valid)
      else $error("back end took a word from an empty queue");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

endmodule

// ----- hw/rtl/bda_front.sv -----
// Front end: accepts input words into a two-entry queue and flags zero values.
module bda_front
   import bda_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [31:0]           req_value,
   output logic                  req_full,
   output bda_hand_type          hand,
   output logic [VALUE_BITS-1:0] hand_value,
   input  logic                  take
);

   localparam int DEPTH = 2;

   logic [VALUE_BITS-1:0] mem_ff [DEPTH];
   logic                  zero_ff [DEPTH];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push_ok;
   logic                  pop_ok;
   logic [63:0]           value_ext;
   logic [VALUE_BITS-1:0] value_cut;

   assign value_ext = 64'(req_value);
   assign value_cut = value_ext[VALUE_BITS-1:0];

   assign req_full = (count_ff == 2'(DEPTH));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = take && (count_ff != 2'd0);

   assign hand.valid   = (count_ff != 2'd0);
   assign hand.is_zero = zero_ff[rd_ptr_ff];
   assign hand_value   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 2'd1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff]  <= value_cut;
         zero_ff[wr_ptr_ff] <= (value_cut == '0);
      end
   end

endmodule

// ----- hw/rtl/bda_back.sv -----
// Back end: shift-add-3 conversion; one digit a cycle unless output stalls.
module bda_back
   import bda_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bda_hand_type          hand,
   input  logic [VALUE_BITS-1:0] hand_value,
   output logic                  take,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [CHAR_BITS-1:0]  rsp_digit_char,
   output logic                  rsp_last_digit
);

   localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCD_W = NUM_DIGITS * DIGIT_BITS;
   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam int REM_W = $clog2(NUM_DIGITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [BCD_W-1:0]      bcd_adj;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [REM_W-1:0]      remain_ff, remain_in;
   logic                  out_valid_ff, out_valid_in;
   logic [CHAR_BITS-1:0]  out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic [DIGIT_BITS-1:0] top_digit;
   logic                  slot_free;

   assign take           = (state_ff == ST_IDLE) && hand.valid;
   assign rsp_empty      = !out_valid_ff;
   assign rsp_digit_char = out_char_ff;
   assign rsp_last_digit = out_last_ff;
   assign top_digit      = bcd_ff[BCD_W-1 -: DIGIT_BITS];
   assign slot_free      = !out_valid_ff || rsp_pop;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
         end else begin
            bcd_adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      remain_in    = remain_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (hand.valid) begin
               bin_in    = hand_value;
               bcd_in    = '0;
               cnt_in    = '0;
               remain_in = REM_W'(NUM_DIGITS);
               state_in  = hand.is_zero ? ST_SKIP : ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_BITS-1]};
            bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((top_digit == '0) && (remain_ff > REM_W'(1))) begin
               bcd_in    = {bcd_ff[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
               remain_in = remain_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_char_in  = ASCII_ZERO + CHAR_BITS'(top_digit);
               out_last_in  = (remain_ff == REM_W'(1));
               bcd_in       = {bcd_ff[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
               remain_in    = remain_ff - 1'b1;
               if (remain_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      remain_ff   <= remain_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
